// ----- design/sobel_edge_magnitude_3x3_defines.svh -----
// Assertion macros used by the checker file of the Sobel edge block.
// Depends on nothing; included by the checker only.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define SEM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sobel checker: implication violated");

// Next-cycle implication, masked while reset is high.
`define SEM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sobel checker: next-cycle property violated");

// Implication that also holds across reset.
`define SEM_ASSERT_ALW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("sobel checker: reset property violated");

`endif

// ----- design/sem_pkg.sv -----
// Shared constants, types and register codes of the Sobel edge magnitude block.
// Depends on nothing; imported by every module of the block but the checker.
package sem_pkg;

   // pixel and frame geometry
   localparam int PIX_W        = 8;
   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MIN_SIZE     = 3;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);

   // configuration register widths and reset values
   localparam int IN_WIDTH_W   = 12;
   localparam int IN_HEIGHT_W  = 13;
   localparam int SCALE_W      = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int SCALE_RESET  = 4096;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE     = 2'd2;

   // gradient arithmetic: |gx|,|gy| <= 1020
   localparam int GRAD_W       = 11;
   localparam int SQ_W         = 20;
   localparam int SUM_W        = 21;

   // fixed-point root and gain
   localparam int ROOT_FRAC_BITS       = 8;
   localparam int SCALE_FRAC_BITS      = 12;
   localparam int SQRT_STEPS_PER_STAGE = 4;
   localparam int SQRT_STAGES          = 5;
   localparam int ROOT_W    = SQRT_STEPS_PER_STAGE * SQRT_STAGES;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 2;
   localparam int PROD_W    = ROOT_W + SCALE_W;
   localparam int MAG_SHIFT = ROOT_FRAC_BITS + SCALE_FRAC_BITS;

   // live configuration, already clamped
   typedef struct packed {
      logic [COL_W-1:0]   last_col;
      logic [ROW_W-1:0]   last_row;
      logic [SCALE_W-1:0] scale;
   } sem_cfg_type;

   // end-of-row / end-of-frame marks riding with a result
   typedef struct packed {
      logic row_end;
      logic frame_end;
   } sem_tag_type;

endpackage

// ----- design/sem_csr.sv -----
// Configuration registers of the Sobel edge block: frame size and gain.
// Depends on sem_pkg; sizes are clamped at write time.
module sem_csr
   import sem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output sem_cfg_type            cfg
);

   logic [COL_W-1:0]       last_col_ff, last_col_in;
   logic [ROW_W-1:0]       last_row_ff, last_row_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic [IN_WIDTH_W-1:0]  width_val, width_m1;
   logic [IN_HEIGHT_W-1:0] height_val, height_m1;
   logic                   write;

   assign csr_ready  = 1'b1;
   assign write      = csr_valid && csr_ready;
   assign width_val  = csr_data[IN_WIDTH_W-1:0];
   assign height_val = csr_data[IN_HEIGHT_W-1:0];
   assign width_m1   = width_val - IN_WIDTH_W'(1);
   assign height_m1  = height_val - IN_HEIGHT_W'(1);

   // clamp sizes into range and keep the last index of each
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      scale_in    = scale_ff;
      if (write) begin
         case (csr_index)
            CSR_IN_WIDTH: begin
               if (width_val < IN_WIDTH_W'(MIN_SIZE)) begin
                  last_col_in = COL_W'(MIN_SIZE - 1);
               end else if (width_val > IN_WIDTH_W'(MAX_WIDTH)) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = width_m1[COL_W-1:0];
               end
            end
            CSR_IN_HEIGHT: begin
               if (height_val < IN_HEIGHT_W'(MIN_SIZE)) begin
                  last_row_in = ROW_W'(MIN_SIZE - 1);
               end else if (height_val > IN_HEIGHT_W'(MAX_HEIGHT)) begin
                  last_row_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  last_row_in = height_m1[ROW_W-1:0];
               end
            end
            CSR_SCALE: begin
               scale_in = csr_data[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_W'(MAX_WIDTH - 1);
         last_row_ff <= ROW_W'(MAX_HEIGHT - 1);
         scale_ff    <= SCALE_W'(SCALE_RESET);
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         scale_ff    <= scale_in;
      end
   end

   assign cfg.last_col = last_col_ff;
   assign cfg.last_row = last_row_ff;
   assign cfg.scale    = scale_ff;

endmodule

// ----- design/sem_window.sv -----
// Raster position counters, two line memories, the 3x3 window and the
// Sobel gx/gy sums. Depends on sem_pkg; two register stages.
module sem_window
   import sem_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  sem_cfg_type              cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [PIX_W-1:0]         in_pixel,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [GRAD_W-1:0] out_gx,
   output logic signed [GRAD_W-1:0] out_gy,
   output sem_tag_type              out_tag
);

   // line memories: upper holds row r-2, middle holds row r-1
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept, last_col, last_row, emit;

   // stage 1: memory read data plus the incoming pixel
   logic             s1_v_ff, s1_v_in;
   logic             s1_emit_ff;
   sem_tag_type      s1_tag_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_bot_ff, top_rd_ff, mid_rd_ff;
   logic             s1_leave, s1_free;

   // previous two columns: 0..2 = left T/M/B, 3..5 = middle T/M/B
   logic [PIX_W-1:0] win_ff [6];

   // stage 2: gradient sums
   logic                     s2_v_ff, s2_v_in;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   sem_tag_type              s2_tag_ff;
   logic                     s2_free;

   logic signed [GRAD_W-1:0] tl, ml, bl, tm, bm, tr, mr, br, gx, gy;

   assign s2_free  = !s2_v_ff || out_ready;
   assign s1_free  = !s1_v_ff || s2_free;
   assign s1_leave = s1_v_ff && s2_free;
   assign in_ready = s1_free;
   assign accept   = in_valid && in_ready;

   assign last_col = col_ff >= cfg.last_col;
   assign last_row = row_ff >= cfg.last_row;
   assign emit     = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line memories: read old column, then shift rows down
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff          <= upper_mem[col_ff];
         mid_rd_ff          <= middle_mem[col_ff];
         middle_mem[col_ff] <= in_pixel;
      end
      if (s1_leave) begin
         upper_mem[s1_col_ff] <= mid_rd_ff;
      end
   end

   // stage 1 control and payload
   assign s1_v_in = accept ? 1'b1 : (s2_free ? 1'b0 : s1_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bot_ff           <= in_pixel;
         s1_col_ff           <= col_ff;
         s1_emit_ff          <= emit;
         s1_tag_ff.row_end   <= last_col;
         s1_tag_ff.frame_end <= last_col && last_row;
      end
   end

   // window shifts by one column per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_leave) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_rd_ff;
         win_ff[4] <= mid_rd_ff;
         win_ff[5] <= s1_bot_ff;
      end
   end

   // Sobel sums over the completed window
   assign tl = $signed(GRAD_W'(win_ff[0]));
   assign ml = $signed(GRAD_W'(win_ff[1]));
   assign bl = $signed(GRAD_W'(win_ff[2]));
   assign tm = $signed(GRAD_W'(win_ff[3]));
   assign bm = $signed(GRAD_W'(win_ff[5]));
   assign tr = $signed(GRAD_W'(top_rd_ff));
   assign mr = $signed(GRAD_W'(mid_rd_ff));
   assign br = $signed(GRAD_W'(s1_bot_ff));

   assign gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
   assign gy = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);

   // stage 2: only items that complete a window go on
   assign s2_v_in = s2_free ? (s1_v_ff && s1_emit_ff) : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_v_ff && s1_emit_ff) begin
         gx_ff     <= gx;
         gy_ff     <= gy;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_gx    = gx_ff;
   assign out_gy    = gy_ff;
   assign out_tag   = s2_tag_ff;

endmodule

// ----- design/sem_sqrt.sv -----
// Pipelined digit-by-digit integer square root of (sum << 2*ROOT_FRAC_BITS).
// Depends on sem_pkg; SQRT_STAGES stages of SQRT_STEPS_PER_STAGE digits.
module sem_sqrt
   import sem_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SUM_W-1:0]  in_sum,
   input  sem_tag_type       in_tag,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_root,
   output sem_tag_type       out_tag
);

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sem_sqrt_st_type;

   // one stage worth of result digits
   function automatic sem_sqrt_st_type sqrt_steps(input sem_sqrt_st_type s);
      sem_sqrt_st_type  t;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      t = s;
      for (int i = 0; i < SQRT_STEPS_PER_STAGE; i++) begin
         rem2  = {t.rem[REM_W-3:0], t.rad[RAD_W-1:RAD_W-2]};
         trial = {t.root, 2'b01};
         t.rad = t.rad << 2;
         if (rem2 >= trial) begin
            t.rem  = rem2 - trial;
            t.root = {t.root[ROOT_W-2:0], 1'b1};
         end else begin
            t.rem  = rem2;
            t.root = {t.root[ROOT_W-2:0], 1'b0};
         end
      end
      return t;
   endfunction

   logic            v_ff    [SQRT_STAGES];
   sem_sqrt_st_type st_ff   [SQRT_STAGES];
   sem_tag_type     tag_ff  [SQRT_STAGES];
   logic            free    [SQRT_STAGES+1];
   logic            src_v   [SQRT_STAGES];
   sem_sqrt_st_type src_st  [SQRT_STAGES];
   sem_tag_type     src_tag [SQRT_STAGES];
   sem_sqrt_st_type st_in   [SQRT_STAGES];
   sem_sqrt_st_type first_st;

   // a stage can take an item when empty or when its item moves on
   always_comb begin
      free[SQRT_STAGES] = out_ready;
      for (int k = SQRT_STAGES - 1; k >= 0; k--) begin
         free[k] = !v_ff[k] || free[k+1];
      end
   end

   assign first_st.rad  = RAD_W'(in_sum) << (2 * ROOT_FRAC_BITS);
   assign first_st.rem  = '0;
   assign first_st.root = '0;

   // stage sources and next payload
   always_comb begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            src_v[k]   = in_valid;
            src_st[k]  = first_st;
            src_tag[k] = in_tag;
         end else begin
            src_v[k]   = v_ff[k-1];
            src_st[k]  = st_ff[k-1];
            src_tag[k] = tag_ff[k-1];
         end
         st_in[k] = sqrt_steps(src_st[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            if (free[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (free[k] && src_v[k]) begin
            st_ff[k]  <= st_in[k];
            tag_ff[k] <= src_tag[k];
         end
      end
   end

   assign in_ready  = free[0];
   assign out_valid = v_ff[SQRT_STAGES-1];
   assign out_root  = st_ff[SQRT_STAGES-1].root;
   assign out_tag   = tag_ff[SQRT_STAGES-1];

endmodule

// ----- design/sobel_edge_magnitude_3x3.sv -----
// Sobel 3x3 edge magnitude over a haloed grey frame, one pixel per clock
// when not stalled. From the pixel that completes its window, a result passes
// through 2 window stages, squares, sum, 5 root stages, gain and saturate.
// Stalls back up to req_tready; the first two rows and columns yield no result.
// Reset: synchronous, clears position counters, window, valid bits and registers
// to 2048 x 4096 with unity gain; line memory contents are not cleared.
module sobel_edge_magnitude_3x3
   import sem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input pixels
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] pixel
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] magnitude
   output logic                   rsp_tlast,   // row_end
   output logic                   rsp_tuser,   // [0] frame_end
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   sem_cfg_type cfg;

   logic                     w_valid, w_ready;
   logic signed [GRAD_W-1:0] w_gx, w_gy;
   sem_tag_type              w_tag;

   logic                        s3_v_ff, s3_v_in, s3_free;
   logic [SQ_W-1:0]             gx_sq_ff, gy_sq_ff;
   sem_tag_type                 s3_tag_ff;
   logic signed [2*GRAD_W-1:0]  gx_prod, gy_prod;

   logic             s4_v_ff, s4_v_in, s4_free;
   logic [SUM_W-1:0] sum_ff;
   sem_tag_type      s4_tag_ff;

   logic              sq_in_ready, sq_valid, sq_ready;
   logic [ROOT_W-1:0] sq_root;
   sem_tag_type       sq_tag;

   logic              mul_v_ff, mul_v_in, mul_free;
   logic [PROD_W-1:0] prod_ff;
   sem_tag_type       mul_tag_ff;

   logic              out_v_ff, out_v_in, out_free;
   logic [PIX_W-1:0]  mag_ff;
   sem_tag_type       out_tag_ff;
   logic [PROD_W-1:0] scaled;
   logic [PIX_W-1:0]  mag;

   sem_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sem_window u_window (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (req_tdata),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .out_gx    (w_gx),
      .out_gy    (w_gy),
      .out_tag   (w_tag)
   );

   // backpressure chain, output side first
   assign out_free = !out_v_ff || rsp_tready;
   assign mul_free = !mul_v_ff || out_free;
   assign sq_ready = mul_free;
   assign s4_free  = !s4_v_ff || sq_in_ready;
   assign s3_free  = !s3_v_ff || s4_free;
   assign w_ready  = s3_free;

   // squares of the gradients
   assign gx_prod = w_gx * w_gx;
   assign gy_prod = w_gy * w_gy;
   assign s3_v_in = s3_free ? w_valid : s3_v_ff;

   always_ff @(posedge clock) begin
      if (s3_free && w_valid) begin
         gx_sq_ff  <= gx_prod[SQ_W-1:0];
         gy_sq_ff  <= gy_prod[SQ_W-1:0];
         s3_tag_ff <= w_tag;
      end
   end

   // sum of squares
   assign s4_v_in = s4_free ? s3_v_ff : s4_v_ff;

   always_ff @(posedge clock) begin
      if (s4_free && s3_v_ff) begin
         sum_ff    <= SUM_W'(gx_sq_ff) + SUM_W'(gy_sq_ff);
         s4_tag_ff <= s3_tag_ff;
      end
   end

   sem_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_v_ff),
      .in_ready  (sq_in_ready),
      .in_sum    (sum_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // gain
   assign mul_v_in = mul_free ? sq_valid : mul_v_ff;

   always_ff @(posedge clock) begin
      if (mul_free && sq_valid) begin
         prod_ff    <= PROD_W'(sq_root) * PROD_W'(cfg.scale);
         mul_tag_ff <= sq_tag;
      end
   end

   // drop the fraction bits and saturate to a pixel
   assign scaled   = prod_ff >> MAG_SHIFT;
   assign mag      = (|scaled[PROD_W-1:PIX_W]) ? '1 : scaled[PIX_W-1:0];
   assign out_v_in = out_free ? mul_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (out_free && mul_v_ff) begin
         mag_ff     <= mag;
         out_tag_ff <= mul_tag_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s3_v_ff  <= s3_v_in;
         s4_v_ff  <= s4_v_in;
         mul_v_ff <= mul_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = mag_ff;
   assign rsp_tlast  = out_tag_ff.row_end;
   assign rsp_tuser  = out_tag_ff.frame_end;

endmodule

// ----- design/sem_checker.sv -----
// Port-level checks for the Sobel edge block, bound to the top level.
// Depends on sobel_edge_magnitude_3x3_defines.svh for the assertion macros.
`include "sobel_edge_magnitude_3x3_defines.svh"

module sem_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // a stalled result stays offered and unchanged
   `SEM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // the frame ends only on the last result of a row
   `SEM_ASSERT_IMP(a_frame_on_row_end, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   // a free output side never throttles the input
   `SEM_ASSERT_IMP(a_ready_flows, clock, reset, rsp_tready, req_tready)

   // nothing is offered right after reset
   `SEM_ASSERT_ALW(a_quiet_after_reset, clock, $past(reset), !rsp_tvalid)

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (.*);
